// ===== src/postfix_stack_calculator_top_macros.svh =====
// Assertion macros shared by the postfix calculator checker.
`ifndef POSTFIX_STACK_CALCULATOR_TOP_MACROS_SVH
`define POSTFIX_STACK_CALCULATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PCALC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PCALC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Condition that must hold in the cycle after reset is seen.
`define PCALC_ASSERT_AFTER_RESET(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

// ===== src/pcalc_pkg.sv =====
// Shared types and character codes of the postfix stack calculator.
`default_nettype none
package pcalc_pkg;

   localparam int VALUE_WIDTH = 32;

   typedef logic [VALUE_WIDTH-1:0] value_type;

   localparam logic [7:0] CH_END  = 8'h2E;
   localparam logic [7:0] CH_ADD  = 8'h2B;
   localparam logic [7:0] CH_MUL  = 8'h2A;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_DIGIT,
      OP_TERM,
      OP_ADD,
      OP_MUL,
      OP_END
   } op_kind_type;

   // One character waiting in the input register.
   typedef struct packed {
      logic       valid;
      logic [7:0] ch;
   } item_type;

   // One result headed for the output register.
   typedef struct packed {
      logic      valid;
      value_type value;
      logic      overflowed;
   } result_type;

endpackage
`default_nettype wire

// ===== src/pcalc_input_reg.sv =====
// Input register that holds one accepted character beat.
`default_nettype none
module pcalc_input_reg (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [7:0]          req_tdata,   // [7:0] ch
   input  wire logic                take,
   output pcalc_pkg::item_type      item
);
   import pcalc_pkg::*;

   logic       valid_ff;
   logic [7:0] ch_ff;

   assign req_tready = !valid_ff || take;
   assign item.valid = valid_ff;
   assign item.ch    = ch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         valid_ff <= 1'b1;
      end else if (take) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         ch_ff <= req_tdata;
      end
   end

endmodule
`default_nettype wire

// ===== src/pcalc_core.sv =====
// Stack engine: decodes a character and updates the number, the stack and the flag.
`default_nettype none
module pcalc_core #(
   parameter int STACK_DEPTH = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pcalc_pkg::item_type  item,
   input  wire logic                 out_free,
   output logic                      take,
   output pcalc_pkg::result_type     result
);
   import pcalc_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   // The two top entries live in registers; deeper entries live in the memory,
   // whose top entry is always kept in mem_rd_ff.
   value_type   mem [STACK_DEPTH];
   value_type   mem_rd_ff;

   logic [CW-1:0] count_ff, count_in;
   value_type     t0_ff, t0_in;
   value_type     t1_ff, t1_in;
   value_type     acc_ff, acc_in;
   logic          in_num_ff, in_num_in;
   logic          ovf_ff, ovf_in;

   op_kind_type   op;
   logic          has1, has2, has4, full;
   value_type     opa, opb, sum, prod, acc_next;
   logic [CW-1:0] cm2, cm4;
   logic          wr_en, rd_en, ld_rd;

   always_comb begin
      if (item.ch >= CH_ZERO && item.ch <= CH_NINE) begin
         op = OP_DIGIT;
      end else if (in_num_ff) begin
         op = OP_TERM;
      end else begin
         case (item.ch)
            CH_ADD:  op = OP_ADD;
            CH_MUL:  op = OP_MUL;
            CH_END:  op = OP_END;
            default: op = OP_NONE;
         endcase
      end
   end

   // Only the end marker needs room in the output register.
   assign take = item.valid && (op != OP_END || out_free);

   assign has1 = count_ff != '0;
   assign has2 = count_ff >= CW'(2);
   assign has4 = count_ff >= CW'(4);
   assign full = count_ff == CW'(STACK_DEPTH);
   assign cm2  = count_ff - CW'(2);
   assign cm4  = count_ff - CW'(4);

   assign opa      = has1 ? t0_ff : '0;
   assign opb      = has2 ? t1_ff : '0;
   assign sum      = opa + opb;
   assign prod     = opa * opb;
   assign acc_next = (acc_ff << 3) + (acc_ff << 1) + value_type'(item.ch - CH_ZERO);

   always_comb begin
      count_in  = count_ff;
      t0_in     = t0_ff;
      t1_in     = t1_ff;
      acc_in    = acc_ff;
      in_num_in = in_num_ff;
      ovf_in    = ovf_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      ld_rd     = 1'b0;
      if (take) begin
         case (op)
            OP_DIGIT: begin
               acc_in    = acc_next;
               in_num_in = 1'b1;
            end
            OP_TERM: begin
               acc_in    = '0;
               in_num_in = 1'b0;
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  wr_en    = has2;
                  ld_rd    = 1'b1;
                  t1_in    = t0_ff;
                  t0_in    = acc_ff;
                  count_in = count_ff + CW'(1);
               end
            end
            OP_ADD, OP_MUL: begin
               // Two pops and one push: the memory top moves up into t1 and
               // the entry below it is fetched for the next operator.
               t0_in    = (op == OP_ADD) ? sum : prod;
               t1_in    = mem_rd_ff;
               rd_en    = has4;
               count_in = has2 ? (count_ff - CW'(1)) : CW'(1);
            end
            OP_END: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   assign result.valid      = take && (op == OP_END);
   assign result.value      = opa;
   assign result.overflowed = ovf_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cm2[AW-1:0]] <= t1_ff;
      end
      if (rd_en) begin
         mem_rd_ff <= mem[cm4[AW-1:0]];
      end else if (ld_rd) begin
         mem_rd_ff <= t1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         acc_ff    <= '0;
         in_num_ff <= 1'b0;
         ovf_ff    <= 1'b0;
      end else begin
         count_ff  <= count_in;
         acc_ff    <= acc_in;
         in_num_ff <= in_num_in;
         ovf_ff    <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      t0_ff <= t0_in;
      t1_ff <= t1_in;
   end

endmodule
`default_nettype wire

// ===== src/pcalc_output_reg.sv =====
// Output register that holds one result beat until it is taken.
`default_nettype none
module pcalc_output_reg (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire pcalc_pkg::result_type  result,
   output logic                        out_free,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [39:0]                 rsp_tdata   // [31:0] value, [32] overflowed, [39:33] zero
);
   import pcalc_pkg::*;

   logic      valid_ff;
   value_type value_ff;
   logic      ovf_ff;

   assign out_free   = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'b0, ovf_ff, value_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (result.valid) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         value_ff <= result.value;
         ovf_ff   <= result.overflowed;
      end
   end

endmodule
`default_nettype wire

// ===== src/postfix_stack_calculator_top.sv =====
// Top level of the postfix stack calculator.
// The block takes one ASCII character per beat and sustains one beat per cycle
// while no '.' beat waits for room in the result register, set by a single pass
// through the stack engine between the input register and the result register.
// Digits build a 32-bit number, the first non-digit after a number pushes it,
// '+' and '*' combine the top two entries, and '.' returns the top (0 when empty)
// with the sticky overflow flag and empties the stack. The stack holds
// STACK_DEPTH entries: the top two in registers, the rest in a memory whose top
// entry is prefetched, so no clearing pass is needed after reset.
`default_nettype none
module postfix_stack_calculator_top #(
   parameter int STACK_DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] ch
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata     // [31:0] value, [32] overflowed, [39:33] zero
);
   import pcalc_pkg::*;

   item_type   item;
   result_type result;
   logic       take;
   logic       out_free;

   pcalc_input_reg u_input_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (take),
      .item       (item)
   );

   pcalc_core #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .item     (item),
      .out_free (out_free),
      .take     (take),
      .result   (result)
   );

   pcalc_output_reg u_output_reg (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

// ===== src/pcalc_checker.sv =====
// Port-level checker for the postfix stack calculator, bound to the top level.
`default_nettype none
`include "postfix_stack_calculator_top_macros.svh"
module pcalc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [7:0]  req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);

   logic seen_ff;

   // Remembers that a delivered result already carried the overflow flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready && rsp_tdata[32]) begin
         seen_ff <= 1'b1;
      end
   end

   `PCALC_ASSERT_NEXT(a_req_hold, req_tvalid && !req_tready, req_tvalid && $stable(req_tdata), "character beat changed while stalled")
   `PCALC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result beat changed while stalled")
   `PCALC_ASSERT_NOW(a_ovf_sticky, rsp_tvalid && seen_ff, rsp_tdata[32], "overflow flag dropped after being reported")
   `PCALC_ASSERT_NOW(a_pad_zero, rsp_tvalid, rsp_tdata[39:33] == 7'b0, "result padding bits not zero")
   `PCALC_ASSERT_AFTER_RESET(a_reset_idle, req_tready && !rsp_tvalid, "block not idle after reset")

endmodule

bind postfix_stack_calculator_top pcalc_checker u_checker (.*);
`default_nettype wire

// ===== tb/postfix_stack_calculator_checker.sv =====
// Checker that predicts the calculator's results from the character beats and compares them.
`default_nettype none
module postfix_stack_calculator_checker
   import pcalc_pkg::*;
#(
   parameter int STACK_DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] ch
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [39:0] rsp_tdata,    // [31:0] value, [32] overflowed, [39:33] zero
   output int               fail_count,
   output int               pending
);

   localparam int unsigned RADIX = 10;

   typedef struct {
      value_type value;
      logic      overflowed;
   } top_result_type;

   value_type      stack_mem [STACK_DEPTH];
   int unsigned    stack_level;
   value_type      number_acc;
   logic           in_num;
   logic           ovf_seen;
   int             fails;
   top_result_type expected_tops [$];

   initial begin
      fails = 0;
      fail_count = 0;
      pending = 0;
   end

   function automatic void push_val(value_type v);
      if (stack_level < STACK_DEPTH) begin
         stack_mem[stack_level] = v;
         stack_level++;
      end else begin
         ovf_seen = 1'b1;
      end
   endfunction

   function automatic value_type pop_val();
      if (stack_level == 0) return '0;
      stack_level--;
      return stack_mem[stack_level];
   endfunction

   // Advances the predicted calculator by one character and queues any result it emits.
   function automatic void eval_char(logic [7:0] c);
      value_type      a;
      value_type      b;
      top_result_type r;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         number_acc = number_acc * RADIX + value_type'(c - CH_ZERO);
         in_num = 1'b1;
      end else if (in_num) begin
         // The character that ends a number is swallowed after the push.
         push_val(number_acc);
         number_acc = '0;
         in_num = 1'b0;
      end else if (c == CH_ADD) begin
         a = pop_val();
         b = pop_val();
         push_val(a + b);
      end else if (c == CH_MUL) begin
         a = pop_val();
         b = pop_val();
         push_val(a * b);
      end else if (c == CH_END) begin
         r.value = pop_val();
         r.overflowed = ovf_seen;
         stack_level = 0;
         expected_tops.push_back(r);
      end
   endfunction

   always @(posedge clock) begin
      top_result_type want;
      if (reset) begin
         stack_level = 0;
         number_acc = '0;
         in_num = 1'b0;
         ovf_seen = 1'b0;
         expected_tops.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tops.size() == 0) begin
               $error("result beat with no result expected: value %h", rsp_tdata[31:0]);
               fails++;
            end else begin
               want = expected_tops.pop_front();
               if (rsp_tdata[31:0] !== want.value) begin
                  $error("value: expected %h, actual %h", want.value, rsp_tdata[31:0]);
                  fails++;
               end
               if (rsp_tdata[32] !== want.overflowed) begin
                  $error("overflowed: expected %b, actual %b", want.overflowed, rsp_tdata[32]);
                  fails++;
               end
            end
         end
         if (req_tvalid && req_tready) eval_char(req_tdata);
      end
      fail_count <= fails;
      pending <= expected_tops.size();
   end

endmodule
`default_nettype wire

// ===== tb/postfix_stack_calculator_top_tb.sv =====
// Testbench top: feeds character beats to the calculator, paces the result side, gives the verdict.
`default_nettype none
module postfix_stack_calculator_top_tb;
   import pcalc_pkg::*;

   localparam int         STACK_DEPTH  = 64;
   localparam int         RANDOM_ITEMS = 1700;
   localparam int         HOLD_CYCLES  = 300;
   localparam int         DRAIN_CYCLES = 20;
   localparam int         CYCLE_LIMIT  = 300000;
   localparam int unsigned RADIX       = 10;
   localparam logic [7:0] CH_SPACE     = 8'h20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;     // [7:0] ch
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;          // [31:0] value, [32] overflowed, [39:33] zero

   int fail_count;
   int pending;
   bit idle_on = 1'b1;
   int hold_req = 0;
   int items_sent = 0;
   int cycle_count = 0;
   bit deep_done = 1'b0;

   postfix_stack_calculator_top #(.STACK_DEPTH(STACK_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   postfix_stack_calculator_checker #(.STACK_DEPTH(STACK_DEPTH)) result_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Result side: random back-pressure while idle_on is set, plus a long hold-off whenever the stimulus asks.
   initial begin
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !idle_on || ($urandom_range(99) >= 32);
         end
      end
   end

   task automatic send_char(input logic [7:0] c);
      while (idle_on && $urandom_range(99) < 32) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic send_number(value_type v);
      logic [7:0] digs [$];
      do begin
         digs.push_front(CH_ZERO + 8'(v % RADIX));
         v = v / RADIX;
      end while (v != 0);
      foreach (digs[i]) send_char(digs[i]);
      send_char(CH_SPACE);
   endtask

   // A random digit run, sometimes long enough to wrap, closed by a non-digit.
   task automatic send_operand();
      int         ndig;
      logic [7:0] term;
      case ($urandom_range(3))
         0: ndig = 1;
         1: ndig = $urandom_range(3, 1);
         2: ndig = $urandom_range(10, 1);
         default: ndig = $urandom_range(14, 11);
      endcase
      repeat (ndig) send_char(CH_ZERO + 8'($urandom_range(9)));
      term = CH_SPACE;
      if ($urandom_range(9) == 0) begin
         // Any non-digit ends the number, operators and end markers included.
         do term = 8'($urandom_range(255)); while (term >= CH_ZERO && term <= CH_NINE);
      end
      send_char(term);
   endtask

   // One postfix expression; a stacked one pushes every operand before any operator.
   task automatic send_expression(int pushes, bit stacked);
      int depth;
      int left;
      depth = 0;
      left = pushes;
      while ((left > 0 || depth > 1) && !(left == 0 && $urandom_range(9) == 0)) begin
         if ($urandom_range(19) == 0) begin
            send_char(8'($urandom_range(255)));
         end else if (left > 0 && (depth < 2 || stacked || $urandom_range(1) == 1)) begin
            send_operand();
            depth++;
            left--;
         end else begin
            send_char($urandom_range(1) ? CH_ADD : CH_MUL);
            depth--;
         end
      end
      send_char(CH_END);
   endtask

   task automatic random_until(int target);
      bit deep;
      while (items_sent < target) begin
         deep = items_sent > 1000 && ($urandom_range(24) == 0 || (!deep_done && items_sent > 1400));
         if (deep) begin
            deep_done = 1'b1;
            send_expression($urandom_range(70, 60), 1'b1);
         end else begin
            send_expression($urandom_range(6, 1), 1'b0);
         end
      end
   endtask

   initial begin
      int base;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty pops, zero, the largest value, end marker right after digits.
      send_char(CH_END);
      send_char(CH_ADD);
      send_char(CH_MUL);
      send_char(CH_END);
      send_number('0);
      send_char(CH_END);
      send_number('1);
      send_char(CH_END);
      send_char(CH_NINE);
      send_char(CH_NINE);
      send_char(CH_END);
      send_char(CH_END);
      send_char(8'hFF);
      send_char(8'h00);
      send_number(value_type'(7));
      send_number(value_type'(6));
      send_char(CH_MUL);
      send_char(CH_END);
      wait_drain();

      // The result side holds off while end markers keep coming, so the input stalls.
      hold_req++;
      repeat (40) send_char(CH_END);
      wait_drain();

      base = items_sent;
      random_until(base + 600);
      wait_drain();
      idle_on = 1'b0;
      random_until(base + 900);
      idle_on = 1'b1;
      random_until(base + RANDOM_ITEMS);

      wait_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+src
src/pcalc_pkg.sv
src/pcalc_input_reg.sv
src/pcalc_core.sv
src/pcalc_output_reg.sv
src/postfix_stack_calculator_top.sv
src/pcalc_checker.sv
tb/postfix_stack_calculator_checker.sv
tb/postfix_stack_calculator_top_tb.sv
